// ===== design/mcsc_pkg.sv =====
`default_nettype none

package mcsc_pkg;

    // Input operations
    localparam logic [2:0] OP_NOTE_OFF   = 3'd0;
    localparam logic [2:0] OP_NOTE_ON    = 3'd1;
    localparam logic [2:0] OP_CTRL       = 3'd2;
    localparam logic [2:0] OP_PROGRAM    = 3'd3;
    localparam logic [2:0] OP_PITCH_BEND = 3'd4;

    // Controller numbers
    localparam logic [6:0] CC_DATA_MSB   = 7'd6;
    localparam logic [6:0] CC_VOLUME     = 7'd7;
    localparam logic [6:0] CC_EXPRESSION = 7'd11;
    localparam logic [6:0] CC_DATA_LSB   = 7'd38;
    localparam logic [6:0] CC_RPN_LSB    = 7'd100;
    localparam logic [6:0] CC_RPN_MSB    = 7'd101;
    localparam logic [6:0] CC_SOUND_OFF  = 7'd120;
    localparam logic [6:0] CC_RESET_ALL  = 7'd121;
    localparam logic [6:0] CC_NOTES_OFF  = 7'd123;

    // Output commands
    localparam logic [2:0] CMD_KEY_OFF     = 3'd0;
    localparam logic [2:0] CMD_KEY_ON      = 3'd1;
    localparam logic [2:0] CMD_SET_VOLUMES = 3'd2;
    localparam logic [2:0] CMD_SET_PITCH   = 3'd3;
    localparam logic [2:0] CMD_SEL_TONE    = 3'd4;

    localparam logic [3:0] NOISE_CHANNEL = 4'd9;

    // Channel state reset values
    localparam logic [6:0] RST_RPN        = 7'd127;
    localparam logic [6:0] RST_DATA       = 7'd0;
    localparam logic [6:0] RST_BEND_RANGE = 7'd2;
    localparam logic [6:0] RST_VOLUME     = 7'd64;
    localparam logic [6:0] RST_EXPRESSION = 7'd127;

    // ln2 in Q30, scaled onto the 98304 step of one octave
    localparam logic [31:0] LN2_Q30     = 32'd744261118;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [3:0]  DIV_THREE   = 4'd3;
    localparam logic [3:0]  LAST_TERM   = 4'd12;
    localparam logic [10:0] PITCH_MAX   = 11'd2047;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] channel;
        logic [6:0] first_data;
        logic [6:0] second_data;
    } t_in;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] target_channel;
        logic [4:0] voice_volume;
        logic [4:0] channel_volume;
        logic [6:0] key_number;
        logic [1:0] pitch_integer;
        logic [8:0] pitch_fraction;
        logic [6:0] program_number;
        logic       noise_tone;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        EM_KEY_OFF,
        EM_KEY_ON,
        EM_VOLUMES,
        EM_VOL_ZERO,
        EM_TONE_PROG,
        EM_TONE_RESET,
        EM_PITCH,
        EM_PITCH_RESET
    } t_emit;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_VMUL,
        STEP_E,
        STEP_QR,
        STEP_Y1,
        STEP_Y2,
        STEP_Y3,
        STEP_T1,
        STEP_T2,
        STEP_T3
    } t_step;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_KEYOFF,
        ST_VMUL,
        ST_VOLS,
        ST_KEYON,
        ST_TONE,
        ST_RKEYOFF,
        ST_RTONE,
        ST_RVOL,
        ST_RPITCH,
        ST_PE,
        ST_PQR,
        ST_PY1,
        ST_PY2,
        ST_PY3,
        ST_PT1,
        ST_PT2,
        ST_PT3,
        ST_PEMIT
    } t_state;

    typedef struct packed {
        logic  load;
        logic  apply_cc;
        logic  rst_chan;
        t_step step;
        logic  emit;
        t_emit kind;
        logic  last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] ctrl;
        logic       vel_zero;
        logic       chan_ok;
        logic       chan_noise;
        logic       k_last;
        logic       out_free;
    } t_dp_stat;

    // floor(2^32 / k) for the series divisors
    function automatic logic [32:0] recip(input logic [3:0] k);
        logic [32:0] r;
        unique case (k)
            4'd1:    r = 33'h1_0000_0000;
            4'd2:    r = 33'h0_8000_0000;
            4'd3:    r = 33'h0_5555_5555;
            4'd4:    r = 33'h0_4000_0000;
            4'd5:    r = 33'h0_3333_3333;
            4'd6:    r = 33'h0_2AAA_AAAA;
            4'd7:    r = 33'h0_2492_4924;
            4'd8:    r = 33'h0_2000_0000;
            4'd9:    r = 33'h0_1C71_C71C;
            4'd10:   r = 33'h0_1999_9999;
            4'd11:   r = 33'h0_1745_D174;
            4'd12:   r = 33'h0_1555_5555;
            default: r = 33'h0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/mcsc_dpath.sv =====
`default_nettype none

module mcsc_dpath import mcsc_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in      i_in,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_stat      o_stat,
    input  wire logic     i_out_stall,
    output logic          o_out_valid,
    output t_out          o_out
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_in          r_in;
    logic [IW-1:0] ci;

    logic [6:0] r_pm  [CHANNELS];
    logic [6:0] r_pl  [CHANNELS];
    logic [6:0] r_em  [CHANNELS];
    logic [6:0] r_br  [CHANNELS];
    logic [6:0] r_vol [CHANNELS];
    logic [6:0] r_exp [CHANNELS];

    logic        r_out_valid;
    t_out        r_out;
    t_out        n_out;
    logic        out_free;

    logic [13:0] r_prod;
    logic signed [20:0] r_e;
    logic signed [4:0]  r_q;
    logic [16:0] r_r;
    logic        r_hi;
    logic        r_lo;
    logic [64:0] r_mp;
    logic [31:0] r_x;
    logic [29:0] r_y;
    logic [30:0] r_t;
    logic [31:0] r_s;
    logic [3:0]  r_k;

    assign ci = r_in.channel[IW-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    // Status to the controller
    always_comb begin
        o_stat.op         = r_in.operation;
        o_stat.ctrl       = r_in.first_data;
        o_stat.vel_zero   = (r_in.second_data == 7'd0);
        o_stat.chan_ok    = ({1'b0, r_in.channel} < 5'(CHANNELS));
        o_stat.chan_noise = (r_in.channel == NOISE_CHANNEL);
        o_stat.k_last     = (r_k == LAST_TERM);
        o_stat.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
    end

    // Per-channel controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_pm[c]  <= RST_RPN;
                r_pl[c]  <= RST_RPN;
                r_em[c]  <= RST_DATA;
                r_br[c]  <= RST_BEND_RANGE;
                r_vol[c] <= RST_VOLUME;
                r_exp[c] <= RST_EXPRESSION;
            end
        end else if (i_cmd.rst_chan) begin
            r_pm[ci]  <= RST_RPN;
            r_pl[ci]  <= RST_RPN;
            r_em[ci]  <= RST_DATA;
            r_br[ci]  <= RST_BEND_RANGE;
            r_vol[ci] <= RST_VOLUME;
            r_exp[ci] <= RST_EXPRESSION;
        end else if (i_cmd.apply_cc) begin
            priority case (r_in.first_data)
                CC_DATA_MSB: begin
                    r_em[ci] <= r_in.second_data;
                    if (r_pm[ci] == 7'd0 && r_pl[ci] == 7'd0) begin
                        r_br[ci] <= r_in.second_data;
                    end
                end
                CC_DATA_LSB: begin
                    if (r_pm[ci] == 7'd0 && r_pl[ci] == 7'd0) begin
                        r_br[ci] <= r_em[ci];
                    end
                end
                CC_RPN_LSB:    r_pl[ci]  <= r_in.second_data;
                CC_RPN_MSB:    r_pm[ci]  <= r_in.second_data;
                CC_VOLUME:     r_vol[ci] <= r_in.second_data;
                CC_EXPRESSION: r_exp[ci] <= r_in.second_data;
                default: ;
            endcase
        end
    end

    // Volumes: divide by 127 and by 16129 with a shift estimate and one correction
    logic [11:0] vn;
    logic [4:0]  vq;
    logic [11:0] vrem;
    logic [4:0]  voice_vol;
    logic [18:0] cn;
    logic [4:0]  cq;
    logic [18:0] crem;
    logic [4:0]  chan_vol;

    assign vn        = ({5'd0, r_vol[ci]} << 5) - {5'd0, r_vol[ci]};
    assign vq        = vn[11:7];
    assign vrem      = vn - (({7'd0, vq} << 7) - {7'd0, vq});
    assign voice_vol = vq + 5'(vrem >= 12'd127);
    assign cn        = ({5'd0, r_prod} << 5) - {5'd0, r_prod};
    assign cq        = cn[18:14];
    assign crem      = cn - (({14'd0, cq} << 14) - ({14'd0, cq} << 8) + {14'd0, cq});
    assign chan_vol  = cq + 5'(crem >= 19'd16129);

    // Bend offset times range
    logic signed [14:0] bend_off;
    logic signed [7:0]  range_s;
    logic signed [22:0] e_full;

    assign bend_off = $signed({1'b0, r_in.second_data, r_in.first_data}) - 15'sd8192;
    assign range_s  = $signed({1'b0, r_br[ci]});
    assign e_full   = range_s * bend_off;

    // Octave split: q = floor(e / 98304), r = e - 98304*q
    logic signed [5:0]  m;
    logic [6:0]         mm;
    logic [12:0]        qm;
    logic signed [4:0]  q;
    logic signed [6:0]  qx;
    logic signed [6:0]  q3;
    logic signed [22:0] rr;

    assign m  = r_e[20:15];
    assign mm = 7'($signed({m[5], m}) + 7'sd33);
    assign qm = 13'(mm) * 13'd43;
    assign q  = $signed(qm[11:7]) - 5'sd11;
    assign qx = {{2{q[4]}}, q};
    assign q3 = (qx <<< 1) + qx;
    assign rr = {{2{r_e[20]}}, r_e} - ({{16{q3[6]}}, q3} <<< 15);

    // Shared multiplier and divide-by-small-constant correction
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;
    logic [3:0]  dv;
    logic [31:0] q0;
    logic [35:0] qk;
    logic [35:0] drem;
    logic [31:0] dq;

    always_comb begin
        unique case (i_cmd.step)
            STEP_Y1: begin
                mul_a = 33'(r_r);
                mul_b = LN2_Q30;
            end
            STEP_Y2: begin
                mul_a = recip(DIV_THREE);
                mul_b = r_mp[46:15];
            end
            STEP_T1: begin
                mul_a = 33'(r_t);
                mul_b = 32'(r_y);
            end
            STEP_T2: begin
                mul_a = recip(r_k);
                mul_b = r_mp[61:30];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 65'(mul_a) * 65'(mul_b);
    assign dv    = (i_cmd.step == STEP_Y3) ? DIV_THREE : r_k;
    assign q0    = r_mp[63:32];
    assign qk    = 36'(q0) * 36'(dv);
    assign drem  = 36'(r_x) - qk;
    assign dq    = q0 + 32'(drem >= 36'(dv));

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.step)
            STEP_VMUL: r_prod <= r_in.second_data * r_exp[ci];
            STEP_E:    r_e    <= e_full[20:0];
            STEP_QR: begin
                r_q  <= q;
                r_r  <= rr[16:0];
                r_hi <= (q >= 5'sd2);
                r_lo <= (q <= -5'sd10);
            end
            STEP_Y1: r_mp <= mul_p;
            STEP_Y2: begin
                r_mp <= mul_p;
                r_x  <= r_mp[46:15];
            end
            STEP_Y3: begin
                r_y <= dq[29:0];
                r_s <= ONE_Q30;
                r_t <= ONE_Q30[30:0];
                r_k <= 4'd1;
            end
            STEP_T1: r_mp <= mul_p;
            STEP_T2: begin
                r_mp <= mul_p;
                r_x  <= r_mp[61:30];
            end
            STEP_T3: begin
                r_t <= dq[30:0];
                r_s <= r_s + dq;
                r_k <= r_k + 4'd1;
            end
            default: ;
        endcase
    end

    // Pitch from the series sum, shifted by the octave and clipped
    logic signed [5:0] shs;
    logic [31:0]       ps;
    logic [10:0]       pitch;

    assign shs = 6'sd21 - {r_q[4], r_q};
    assign ps  = r_s >> shs[4:0];

    always_comb begin
        priority if (r_hi) begin
            pitch = PITCH_MAX;
        end else if (r_lo) begin
            pitch = '0;
        end else if (|ps[31:11]) begin
            pitch = PITCH_MAX;
        end else begin
            pitch = ps[10:0];
        end
    end

    always_comb begin
        n_out                = '0;
        n_out.target_channel = r_in.channel;
        n_out.last           = i_cmd.last;
        unique case (i_cmd.kind)
            EM_KEY_OFF: n_out.command = CMD_KEY_OFF;
            EM_KEY_ON: begin
                n_out.command    = CMD_KEY_ON;
                n_out.key_number = r_in.first_data;
            end
            EM_VOLUMES: begin
                n_out.command        = CMD_SET_VOLUMES;
                n_out.voice_volume   = voice_vol;
                n_out.channel_volume = chan_vol;
            end
            EM_VOL_ZERO: n_out.command = CMD_SET_VOLUMES;
            EM_TONE_PROG: begin
                n_out.command        = CMD_SEL_TONE;
                n_out.program_number = r_in.first_data;
            end
            EM_TONE_RESET: begin
                n_out.command    = CMD_SEL_TONE;
                n_out.noise_tone = (r_in.channel == NOISE_CHANNEL);
            end
            EM_PITCH: begin
                n_out.command        = CMD_SET_PITCH;
                n_out.pitch_integer  = pitch[10:9];
                n_out.pitch_fraction = pitch[8:0];
            end
            EM_PITCH_RESET: begin
                n_out.command       = CMD_SET_PITCH;
                n_out.pitch_integer = 2'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== design/mcsc_ctrl.sv =====
`default_nettype none

module mcsc_ctrl import mcsc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_stat.chan_ok) begin
                    n_state = ST_IDLE;
                end else begin
                    priority case (i_stat.op)
                        OP_NOTE_OFF: n_state = ST_KEYOFF;
                        OP_NOTE_ON:  n_state = i_stat.vel_zero ? ST_KEYOFF : ST_VMUL;
                        OP_CTRL: begin
                            priority case (i_stat.ctrl)
                                CC_VOLUME, CC_EXPRESSION:  n_state = ST_VMUL;
                                CC_SOUND_OFF, CC_NOTES_OFF: n_state = ST_KEYOFF;
                                CC_RESET_ALL:              n_state = ST_RKEYOFF;
                                default:                   n_state = ST_IDLE;
                            endcase
                        end
                        OP_PROGRAM:    n_state = i_stat.chan_noise ? ST_IDLE : ST_TONE;
                        OP_PITCH_BEND: n_state = ST_PE;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_KEYOFF:  if (i_stat.out_free) n_state = ST_IDLE;
            ST_VMUL:    n_state = ST_VOLS;
            ST_VOLS: begin
                if (i_stat.out_free) begin
                    n_state = (i_stat.op == OP_NOTE_ON) ? ST_KEYON : ST_IDLE;
                end
            end
            ST_KEYON:   if (i_stat.out_free) n_state = ST_IDLE;
            ST_TONE:    if (i_stat.out_free) n_state = ST_IDLE;
            ST_RKEYOFF: if (i_stat.out_free) n_state = ST_RTONE;
            ST_RTONE:   if (i_stat.out_free) n_state = ST_RVOL;
            ST_RVOL:    if (i_stat.out_free) n_state = ST_RPITCH;
            ST_RPITCH:  if (i_stat.out_free) n_state = ST_IDLE;
            ST_PE:      n_state = ST_PQR;
            ST_PQR:     n_state = ST_PY1;
            ST_PY1:     n_state = ST_PY2;
            ST_PY2:     n_state = ST_PY3;
            ST_PY3:     n_state = ST_PT1;
            ST_PT1:     n_state = ST_PT2;
            ST_PT2:     n_state = ST_PT3;
            ST_PT3:     n_state = i_stat.k_last ? ST_PEMIT : ST_PT1;
            ST_PEMIT:   if (i_stat.out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd.load     = 1'b0;
        o_cmd.apply_cc = 1'b0;
        o_cmd.rst_chan = 1'b0;
        o_cmd.step     = STEP_NONE;
        o_cmd.emit     = 1'b0;
        o_cmd.kind     = EM_KEY_OFF;
        o_cmd.last     = 1'b0;
        o_in_stall     = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE:   o_cmd.load = i_in_valid;
            ST_DECODE: begin
                o_cmd.apply_cc = i_stat.chan_ok && (i_stat.op == OP_CTRL);
                o_cmd.rst_chan = i_stat.chan_ok && (i_stat.op == OP_CTRL)
                                 && (i_stat.ctrl == CC_RESET_ALL);
            end
            ST_KEYOFF: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EM_KEY_OFF;
                o_cmd.last = 1'b1;
            end
            ST_VMUL:   o_cmd.step = STEP_VMUL;
            ST_VOLS: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EM_VOLUMES;
                o_cmd.last = (i_stat.op != OP_NOTE_ON);
            end
            ST_KEYON: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EM_KEY_ON;
                o_cmd.last = 1'b1;
            end
            ST_TONE: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EM_TONE_PROG;
                o_cmd.last = 1'b1;
            end
            ST_RKEYOFF: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EM_KEY_OFF;
            end
            ST_RTONE: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EM_TONE_RESET;
            end
            ST_RVOL: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EM_VOL_ZERO;
            end
            ST_RPITCH: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EM_PITCH_RESET;
                o_cmd.last = 1'b1;
            end
            ST_PE:  o_cmd.step = STEP_E;
            ST_PQR: o_cmd.step = STEP_QR;
            ST_PY1: o_cmd.step = STEP_Y1;
            ST_PY2: o_cmd.step = STEP_Y2;
            ST_PY3: o_cmd.step = STEP_Y3;
            ST_PT1: o_cmd.step = STEP_T1;
            ST_PT2: o_cmd.step = STEP_T2;
            ST_PT3: o_cmd.step = STEP_T3;
            ST_PEMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EM_PITCH;
                o_cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/midi_channel_to_synth_commands_top.sv =====
`default_nettype none

// MIDI channel message to synth command converter. Each input transaction is
// one decoded channel message (note off/on, control change, program change,
// pitch bend); it produces zero to four output transactions, the final one
// flagged by last. Per-channel state (RPN, data entry, bend range, volume,
// expression) lives in flip-flops and returns to its defaults on reset or on
// controller 121. The block handles one message at a time: a message is
// decoded, the volume product is formed where one is needed, and then its
// commands are emitted one after another. Pitch bend evaluates 2^x as a
// 12-term series run through one shared 33x32 multiplier, three steps per
// term (product, reciprocal multiply, divide correction), after the octave
// split and ln2 scaling.
// A new message is accepted while the last command still sits in the output
// register; each command waits only for that register to free up.
module midi_channel_to_synth_commands_top import mcsc_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer: decodes the message and steps the datapath command by command
    mcsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Channel state, volume and pitch arithmetic, output register
    mcsc_dpath #(
        .CHANNELS (CHANNELS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
    import mcsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    midi_channel_to_synth_commands_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the per-channel controller state
    logic [6:0] rpn_msb [16];
    logic [6:0] rpn_lsb [16];
    logic [6:0] entry_msb [16];
    logic [6:0] entry_lsb [16];
    logic [6:0] bend_rng [16];
    logic [6:0] vol_lvl [16];
    logic [6:0] expr_lvl [16];

    t_in  pending_msgs[$];
    t_out expected_cmds[$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_off_req = 1'b0;
    int   hold_count = 0;
    bit   stim_done = 1'b0;
    bit   in_taken = 1'b0;
    int   errors = 0;
    int   quiet_cycles = 0;

    function automatic void clear_channel(input int c);
        rpn_msb[c] = RST_RPN;
        rpn_lsb[c] = RST_RPN;
        entry_msb[c] = RST_DATA;
        entry_lsb[c] = RST_DATA;
        bend_rng[c] = RST_BEND_RANGE;
        vol_lvl[c] = RST_VOLUME;
        expr_lvl[c] = RST_EXPRESSION;
    endfunction

    // 512*2^(e/98304) via truncated series, same rounding at every step
    function automatic logic [10:0] bend_to_pitch(input longint e);
        longint q, r;
        logic [63:0] y, s, t, p;
        if (e >= 0) q = e / 98304;
        else q = -((-e + 98303) / 98304);
        r = e - q * 98304;
        if (q >= 2) return PITCH_MAX;
        if (q <= -10) return 11'd0;
        y = (64'(r) * 64'd744261118) / 64'd98304;
        s = 64'd1 << 30;
        t = 64'd1 << 30;
        for (int k = 1; k <= 12; k++) begin
            t = ((t * y) >> 30) / 64'(k);
            s += t;
        end
        p = s >> (21 - q);
        if (p > 64'd2047) p = 64'd2047;
        return p[10:0];
    endfunction

    function automatic t_out blank_cmd(input logic [2:0] cmd, input logic [3:0] ch);
        t_out o;
        o = '0;
        o.command = cmd;
        o.target_channel = ch;
        return o;
    endfunction

    function automatic t_out volume_cmd(input logic [3:0] ch, input int a, input int b);
        t_out o;
        o = blank_cmd(CMD_SET_VOLUMES, ch);
        o.voice_volume = 5'((31 * vol_lvl[ch]) / 127);
        o.channel_volume = 5'((31 * a * b) / 16129);
        return o;
    endfunction

    // Update channel state and queue the commands one message produces
    task automatic predict_commands(input t_in m);
        t_out cmds[$];
        t_out o;
        logic [3:0] ch;
        longint bend, e;
        logic [10:0] p;
        ch = m.channel;
        case (m.operation)
            OP_NOTE_OFF: cmds.push_back(blank_cmd(CMD_KEY_OFF, ch));
            OP_NOTE_ON: begin
                if (m.second_data == 0) begin
                    cmds.push_back(blank_cmd(CMD_KEY_OFF, ch));
                end else begin
                    cmds.push_back(volume_cmd(ch, m.second_data, expr_lvl[ch]));
                    o = blank_cmd(CMD_KEY_ON, ch);
                    o.key_number = m.first_data;
                    cmds.push_back(o);
                end
            end
            OP_CTRL: begin
                case (m.first_data)
                    CC_DATA_MSB, CC_DATA_LSB: begin
                        if (m.first_data == CC_DATA_MSB) entry_msb[ch] = m.second_data;
                        else entry_lsb[ch] = m.second_data;
                        if (rpn_msb[ch] == 0 && rpn_lsb[ch] == 0)
                            bend_rng[ch] = entry_msb[ch];
                    end
                    CC_RPN_LSB: rpn_lsb[ch] = m.second_data;
                    CC_RPN_MSB: rpn_msb[ch] = m.second_data;
                    CC_VOLUME: begin
                        vol_lvl[ch] = m.second_data;
                        cmds.push_back(volume_cmd(ch, m.second_data, expr_lvl[ch]));
                    end
                    CC_EXPRESSION: begin
                        expr_lvl[ch] = m.second_data;
                        cmds.push_back(volume_cmd(ch, m.second_data, m.second_data));
                    end
                    CC_SOUND_OFF, CC_NOTES_OFF: cmds.push_back(blank_cmd(CMD_KEY_OFF, ch));
                    CC_RESET_ALL: begin
                        clear_channel(ch);
                        cmds.push_back(blank_cmd(CMD_KEY_OFF, ch));
                        o = blank_cmd(CMD_SEL_TONE, ch);
                        o.noise_tone = (ch == NOISE_CHANNEL);
                        cmds.push_back(o);
                        cmds.push_back(blank_cmd(CMD_SET_VOLUMES, ch));
                        o = blank_cmd(CMD_SET_PITCH, ch);
                        o.pitch_integer = 2'd1;
                        cmds.push_back(o);
                    end
                    default: ;
                endcase
            end
            OP_PROGRAM: begin
                if (ch != NOISE_CHANNEL) begin
                    o = blank_cmd(CMD_SEL_TONE, ch);
                    o.program_number = m.first_data;
                    cmds.push_back(o);
                end
            end
            OP_PITCH_BEND: begin
                bend = longint'({m.second_data, m.first_data});
                e = longint'(bend_rng[ch]) * (bend - 8192);
                p = bend_to_pitch(e);
                o = blank_cmd(CMD_SET_PITCH, ch);
                o.pitch_integer = p[10:9];
                o.pitch_fraction = p[8:0];
                cmds.push_back(o);
            end
            default: ;
        endcase
        if (cmds.size() > 0) cmds[cmds.size() - 1].last = 1'b1;
        foreach (cmds[i]) expected_cmds.push_back(cmds[i]);
    endtask

    // Rising edge: record accepted transactions, compare results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_commands(i_in);
                void'(pending_msgs.pop_front());
                in_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected command %p", $time, o_out);
                    errors++;
                end else begin
                    t_out want;
                    want = expected_cmds.pop_front();
                    if (o_out !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, o_out);
                        errors++;
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Driver: hold the offered transaction until taken, then advance the queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_taken = 1'b0;
        end else if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (pending_msgs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in <= pending_msgs[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_off_req && hold_count == 0) hold_count = 300;
            if (hold_count > 0) begin
                hold_count--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
            if (hold_count == 0) hold_off_req = 1'b0;
        end
    end

    // Watchdog: stop if nothing moves for too long
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_in make_msg(input logic [2:0] op, input int ch,
                                     input int d1, input int d2);
        t_in m;
        m.operation = op;
        m.channel = 4'(ch);
        m.first_data = 7'(d1);
        m.second_data = 7'(d2);
        return m;
    endfunction

    // Mostly well-formed traffic; RPN 0/0 sequences to move the bend range
    task automatic queue_random(input int n);
        int ch, pick;
        for (int i = 0; i < n; i++) begin
            ch = $urandom_range(15);
            pick = $urandom_range(99);
            if (pick < 12) begin
                pending_msgs.push_back(make_msg(OP_CTRL, ch, CC_RPN_MSB, 0));
                pending_msgs.push_back(make_msg(OP_CTRL, ch, CC_RPN_LSB, 0));
                pending_msgs.push_back(make_msg(OP_CTRL, ch, CC_DATA_MSB,
                                                $urandom_range(24)));
                pending_msgs.push_back(make_msg(OP_PITCH_BEND, ch,
                                                $urandom_range(127), $urandom_range(127)));
            end else if (pick < 30) begin
                pending_msgs.push_back(make_msg(OP_NOTE_ON, ch,
                                                $urandom_range(127), $urandom_range(127)));
            end else if (pick < 40) begin
                pending_msgs.push_back(make_msg(OP_NOTE_OFF, ch,
                                                $urandom_range(127), $urandom_range(127)));
            end else if (pick < 62) begin
                int cc_list[12] = '{6, 7, 11, 38, 100, 101, 120, 121, 123, 0, 64, 127};
                int cc;
                cc = ($urandom_range(3) == 0) ? $urandom_range(127)
                                              : cc_list[$urandom_range(11)];
                pending_msgs.push_back(make_msg(OP_CTRL, ch, cc, $urandom_range(127)));
            end else if (pick < 72) begin
                pending_msgs.push_back(make_msg(OP_PROGRAM, ch,
                                                $urandom_range(127), $urandom_range(127)));
            end else if (pick < 95) begin
                pending_msgs.push_back(make_msg(OP_PITCH_BEND, ch,
                                                $urandom_range(127), $urandom_range(127)));
            end else begin
                pending_msgs.push_back(make_msg(3'($urandom_range(7, 5)), ch,
                                                $urandom_range(127), $urandom_range(127)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_msgs.size() > 0 || expected_cmds.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        for (int c = 0; c < 16; c++) clear_channel(c);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every operation, field extremes, reset-all, noise channel
        pending_msgs.push_back(make_msg(OP_NOTE_OFF, 0, 0, 0));
        pending_msgs.push_back(make_msg(OP_NOTE_ON, 15, 127, 127));
        pending_msgs.push_back(make_msg(OP_NOTE_ON, 3, 60, 0));
        pending_msgs.push_back(make_msg(OP_NOTE_ON, 3, 0, 1));
        pending_msgs.push_back(make_msg(OP_CTRL, 2, CC_VOLUME, 0));
        pending_msgs.push_back(make_msg(OP_CTRL, 2, CC_EXPRESSION, 127));
        pending_msgs.push_back(make_msg(OP_CTRL, 2, CC_EXPRESSION, 0));
        pending_msgs.push_back(make_msg(OP_CTRL, 4, CC_SOUND_OFF, 5));
        pending_msgs.push_back(make_msg(OP_CTRL, 4, CC_NOTES_OFF, 5));
        pending_msgs.push_back(make_msg(OP_CTRL, 9, CC_RESET_ALL, 0));
        pending_msgs.push_back(make_msg(OP_CTRL, 2, CC_RESET_ALL, 127));
        pending_msgs.push_back(make_msg(OP_CTRL, 5, 127, 127));
        pending_msgs.push_back(make_msg(OP_PROGRAM, 9, 10, 0));
        pending_msgs.push_back(make_msg(OP_PROGRAM, 1, 127, 127));
        pending_msgs.push_back(make_msg(OP_PITCH_BEND, 0, 0, 0));
        pending_msgs.push_back(make_msg(OP_PITCH_BEND, 0, 127, 127));
        pending_msgs.push_back(make_msg(OP_PITCH_BEND, 0, 0, 64));
        pending_msgs.push_back(make_msg(OP_CTRL, 6, CC_RPN_MSB, 0));
        pending_msgs.push_back(make_msg(OP_CTRL, 6, CC_RPN_LSB, 0));
        pending_msgs.push_back(make_msg(OP_CTRL, 6, CC_DATA_MSB, 127));
        pending_msgs.push_back(make_msg(OP_CTRL, 6, CC_DATA_LSB, 127));
        pending_msgs.push_back(make_msg(OP_PITCH_BEND, 6, 127, 127));
        pending_msgs.push_back(make_msg(OP_PITCH_BEND, 6, 0, 0));
        pending_msgs.push_back(make_msg(3'd7, 6, 127, 127));
        wait_drained();

        // Random, phase one: sender idles little, receiver idles a lot
        send_idle_pct = 23;
        recv_idle_pct = 56;
        queue_random(90);
        hold_off_req = 1'b1;
        wait_drained();

        send_idle_pct = 56;
        recv_idle_pct = 23;
        queue_random(110);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(110);
        wait_drained();

        stim_done = 1'b1;
        if (errors == 0 && expected_cmds.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
